// ----- rtl/core/sclex_pkg.sv -----
// sclex_pkg: shared types, token kind codes, character classes and the keyword table
// for the source code lexer. No dependencies.

package sclex_pkg;

	typedef logic [5:0] kind_t;

	localparam kind_t KIND_IDENT     = 6'd9;
	localparam kind_t KIND_NUMBER    = 6'd10;
	localparam kind_t KIND_AND_AND   = 6'd11;
	localparam kind_t KIND_OR_OR     = 6'd12;
	localparam kind_t KIND_EQ_EQ     = 6'd13;
	localparam kind_t KIND_NOT_EQ    = 6'd14;
	localparam kind_t KIND_LESS_EQ   = 6'd15;
	localparam kind_t KIND_GREATER_EQ = 6'd16;
	localparam kind_t KIND_ASSIGN    = 6'd17;
	localparam kind_t KIND_NOT       = 6'd18;
	localparam kind_t KIND_LESS      = 6'd19;
	localparam kind_t KIND_GREATER   = 6'd20;
	localparam kind_t KIND_PLUS      = 6'd21;
	localparam kind_t KIND_MINUS     = 6'd22;
	localparam kind_t KIND_STAR      = 6'd23;
	localparam kind_t KIND_SLASH     = 6'd24;
	localparam kind_t KIND_LPAREN    = 6'd25;
	localparam kind_t KIND_RPAREN    = 6'd26;
	localparam kind_t KIND_LBRACE    = 6'd27;
	localparam kind_t KIND_RBRACE    = 6'd28;
	localparam kind_t KIND_COMMA     = 6'd29;
	localparam kind_t KIND_SEMI      = 6'd30;
	localparam kind_t KIND_UNKNOWN   = 6'd31;
	localparam kind_t KIND_EOF       = 6'd32;
	localparam kind_t KIND_NONE      = 6'd0;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_INT,
		MODE_FRAC,
		MODE_OP
	} lex_mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic [7:0]  unknown_byte;
		logic        run_last;
	} token_t;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int FILL_W     = 3;

	localparam int KW_COUNT   = 9;
	localparam int KW_MAX_LEN = 8;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
		'{"f", "u", "n", "c", "t", "i", "o", "n"},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
		'{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00}
	};

	localparam logic [4:0] KW_LEN [KW_COUNT] = '{
		5'd8, 5'd2, 5'd4, 5'd5, 5'd6, 5'd3, 5'd5, 5'd4, 5'd6
	};

	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_DOT        = 8'h2e;
	localparam logic [7:0] CH_NEWLINE    = 8'h0a;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_op_start(input logic [7:0] c);
		return c == "&" || c == "|" || c == "=" || c == "!" || c == "<" || c == ">";
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			"=":     k = KIND_ASSIGN;
			"!":     k = KIND_NOT;
			"<":     k = KIND_LESS;
			">":     k = KIND_GREATER;
			"+":     k = KIND_PLUS;
			"-":     k = KIND_MINUS;
			"*":     k = KIND_STAR;
			"/":     k = KIND_SLASH;
			"(":     k = KIND_LPAREN;
			")":     k = KIND_RPAREN;
			"{":     k = KIND_LBRACE;
			"}":     k = KIND_RBRACE;
			",":     k = KIND_COMMA;
			";":     k = KIND_SEMI;
			default: k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	// KIND_NONE when the two bytes do not form an operator
	function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
		kind_t k;
		k = KIND_NONE;
		if (a == "&" && b == "&") k = KIND_AND_AND;
		else if (a == "|" && b == "|") k = KIND_OR_OR;
		else if (a == "=" && b == "=") k = KIND_EQ_EQ;
		else if (a == "!" && b == "=") k = KIND_NOT_EQ;
		else if (a == "<" && b == "=") k = KIND_LESS_EQ;
		else if (a == ">" && b == "=") k = KIND_GREATER_EQ;
		return k;
	endfunction

	// prefix holds the first eight identifier bytes, byte 0 in the low bits
	function automatic kind_t keyword_kind(input logic [63:0] prefix, input logic [4:0] len);
		kind_t k;
		logic  hit;
		k = KIND_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			hit = (len == KW_LEN[i]);
			for (int j = 0; j < KW_MAX_LEN; j++) begin
				if (5'(j) < KW_LEN[i] && prefix[8*j +: 8] != KW_TEXT[i][j]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				k = 6'(i);
			end
		end
		return k;
	endfunction

endpackage

// ----- rtl/core/sclex_if.sv -----
// sclex_if: valid/ready channel interfaces for the source code lexer, one for
// source bytes and one for tokens. No dependencies.

interface sclex_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch_byte;
	logic       end_of_input;

	modport source (output valid, output ch_byte, output end_of_input, input ready);
	modport sink (input valid, input ch_byte, input end_of_input, output ready);
endinterface

interface sclex_token_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic [7:0]  unknown_byte;
	logic        run_last;

	modport source (output valid, output token_kind, output token_start, output token_length,
		output line_number, output unknown_byte, output run_last, input ready);
	modport sink (input valid, input token_kind, input token_start, input token_length,
		input line_number, input unknown_byte, input run_last, output ready);
endinterface

// ----- rtl/core/source_code_lexer_top.sv -----
// source_code_lexer_top: streaming lexer, one source byte per transfer in, tokens out.
// Depends on sclex_pkg and the channel interfaces in sclex_if.sv.

// The lexer takes one byte per cycle: a byte is registered on transfer and lexed from
// that register against the lexer state, and the zero, one or two tokens it closes go
// into a four-entry result queue. The input keeps taking a byte every cycle as long as
// the queue has two free entries; since the queue drains one token per cycle at most,
// and only while the receiver is ready, bytes that close two tokens (a word, number or
// pending operator ended by a one-byte symbol or unknown byte, an end item that flushes
// a pending token) fill it faster than it drains and can briefly hold off the input.
// Offsets, lengths and line numbers count in COUNT_WIDTH bits, saturate, and leave on
// the 16-bit fields as their low bits. Identifiers up to KEYWORD_BYTES long keep their
// bytes for the keyword compare; longer ones are plain identifiers.

module source_code_lexer_top #(
	parameter int KEYWORD_BYTES = 8,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sclex_text_if.sink           text,
	sclex_token_if.source        token
);

	localparam int IC_W  = $clog2(KEYWORD_BYTES + 2);
	localparam int IDX_W = $clog2(KEYWORD_BYTES);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// lexer state
	sclex_pkg::lex_mode_t   mode_q, mode_d;
	logic [7:0]             prefix_q [KEYWORD_BYTES];
	logic [IC_W-1:0]        ident_cnt_q, ident_cnt_d;
	logic [7:0]             pend_q, pend_d;
	logic [COUNT_WIDTH-1:0] tsr_q, tsr_d;
	logic [COUNT_WIDTH-1:0] pos_q, pos_d;
	logic [COUNT_WIDTH-1:0] line_q, line_d;

	logic                   pre_we;
	logic [IDX_W-1:0]       pre_idx;

	// result queue
	sclex_pkg::token_t       fifo_q [sclex_pkg::FIFO_DEPTH];
	logic [sclex_pkg::PTR_W-1:0]  head_q, tail_q;
	logic [sclex_pkg::FILL_W-1:0] fill_q;

	logic step, pop;
	logic [1:0] push_n;
	sclex_pkg::token_t tok_a, tok_b, flush_tok, r0, r1;
	logic a_vld, b_vld, flush_vld, do_flush, do_begin;
	logic [63:0] prefix64;
	sclex_pkg::kind_t kind_pair, kind_single_pend, kind_single_c;

	assign step = valid_s1 &&
		(fill_q <= sclex_pkg::FILL_W'(sclex_pkg::FIFO_DEPTH - 2));
	assign pop  = token.valid && token.ready;
	assign text.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.ch_byte;
			eoi_s1  <= text.end_of_input;
		end
	end

	always_comb begin
		prefix64 = '0;
		for (int j = 0; j < sclex_pkg::KW_MAX_LEN; j++) begin
			prefix64[8*j +: 8] = prefix_q[j];
		end
	end

	assign kind_pair        = sclex_pkg::pair_kind(pend_q, byte_s1);
	assign kind_single_pend = sclex_pkg::single_kind(pend_q);
	assign kind_single_c    = sclex_pkg::single_kind(byte_s1);

	// token closed by the pending state
	always_comb begin
		flush_vld = 1'b1;
		flush_tok = '0;
		flush_tok.start  = 16'(tsr_q);
		flush_tok.length = 16'(pos_q - tsr_q);
		flush_tok.line   = 16'(line_q);
		case (mode_q)
			sclex_pkg::MODE_IDENT: begin
				flush_tok.kind = sclex_pkg::keyword_kind(prefix64, 5'(ident_cnt_q));
			end
			sclex_pkg::MODE_INT, sclex_pkg::MODE_FRAC: begin
				flush_tok.kind = sclex_pkg::KIND_NUMBER;
			end
			sclex_pkg::MODE_OP: begin
				flush_tok.kind   = kind_single_pend;
				flush_tok.length = 16'd1;
				flush_tok.unknown_byte =
					(kind_single_pend == sclex_pkg::KIND_UNKNOWN) ? pend_q : 8'h00;
			end
			default: flush_vld = 1'b0;
		endcase
	end

	always_comb begin
		mode_d      = mode_q;
		ident_cnt_d = ident_cnt_q;
		pend_d      = pend_q;
		tsr_d       = tsr_q;
		pos_d       = pos_q;
		line_d      = line_q;
		pre_we      = 1'b0;
		pre_idx     = ident_cnt_q[IDX_W-1:0];
		a_vld       = 1'b0;
		b_vld       = 1'b0;
		tok_a       = '0;
		tok_b       = '0;
		do_flush    = 1'b0;
		do_begin    = 1'b0;

		if (eoi_s1) begin
			do_flush = 1'b1;
			b_vld = 1'b1;
			tok_b.kind  = sclex_pkg::KIND_EOF;
			tok_b.start = 16'(pos_q);
			tok_b.line  = 16'(line_q);
		end else begin
			case (mode_q)
				sclex_pkg::MODE_IDENT: begin
					if (sclex_pkg::is_alpha(byte_s1) || sclex_pkg::is_digit(byte_s1) ||
						byte_s1 == sclex_pkg::CH_UNDERSCORE) begin
						pre_we = (ident_cnt_q < IC_W'(KEYWORD_BYTES));
						if (ident_cnt_q <= IC_W'(KEYWORD_BYTES)) begin
							ident_cnt_d = ident_cnt_q + IC_W'(1);
						end
					end else begin
						do_flush = 1'b1;
						do_begin = 1'b1;
					end
				end
				sclex_pkg::MODE_INT: begin
					if (sclex_pkg::is_digit(byte_s1)) begin
						mode_d = sclex_pkg::MODE_INT;
					end else if (byte_s1 == sclex_pkg::CH_DOT) begin
						mode_d = sclex_pkg::MODE_FRAC;
					end else begin
						do_flush = 1'b1;
						do_begin = 1'b1;
					end
				end
				sclex_pkg::MODE_FRAC: begin
					if (!sclex_pkg::is_digit(byte_s1)) begin
						do_flush = 1'b1;
						do_begin = 1'b1;
					end
				end
				sclex_pkg::MODE_OP: begin
					if (kind_pair != sclex_pkg::KIND_NONE) begin
						a_vld = 1'b1;
						tok_a.kind   = kind_pair;
						tok_a.start  = 16'(tsr_q);
						tok_a.length = 16'd2;
						tok_a.line   = 16'(line_q);
						mode_d = sclex_pkg::MODE_IDLE;
					end else begin
						do_flush = 1'b1;
						do_begin = 1'b1;
					end
				end
				default: do_begin = 1'b1;
			endcase
			if (pos_q < CNT_MAX) begin
				pos_d = pos_q + COUNT_WIDTH'(1);
			end
		end

		if (do_flush) begin
			a_vld  = flush_vld;
			tok_a  = flush_tok;
			mode_d = sclex_pkg::MODE_IDLE;
		end

		if (do_begin) begin
			mode_d = sclex_pkg::MODE_IDLE;
			if (sclex_pkg::is_space(byte_s1)) begin
				if (byte_s1 == sclex_pkg::CH_NEWLINE && line_q < CNT_MAX) begin
					line_d = line_q + COUNT_WIDTH'(1);
				end
			end else if (sclex_pkg::is_alpha(byte_s1) || byte_s1 == sclex_pkg::CH_UNDERSCORE) begin
				mode_d      = sclex_pkg::MODE_IDENT;
				tsr_d       = pos_q;
				pre_we      = 1'b1;
				pre_idx     = '0;
				ident_cnt_d = IC_W'(1);
			end else if (sclex_pkg::is_digit(byte_s1)) begin
				mode_d = sclex_pkg::MODE_INT;
				tsr_d  = pos_q;
			end else if (sclex_pkg::is_op_start(byte_s1)) begin
				mode_d = sclex_pkg::MODE_OP;
				pend_d = byte_s1;
				tsr_d  = pos_q;
			end else begin
				b_vld = 1'b1;
				tok_b.kind   = kind_single_c;
				tok_b.start  = 16'(pos_q);
				tok_b.length = 16'd1;
				tok_b.line   = 16'(line_q);
				tok_b.unknown_byte =
					(kind_single_c == sclex_pkg::KIND_UNKNOWN) ? byte_s1 : 8'h00;
			end
		end
	end

	// order the results of this byte: pending token first
	always_comb begin
		r0 = a_vld ? tok_a : tok_b;
		r0.run_last = !(a_vld && b_vld);
		r1 = tok_b;
		r1.run_last = 1'b1;
		push_n = step ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= sclex_pkg::MODE_IDLE;
			ident_cnt_q <= '0;
			pend_q      <= '0;
			tsr_q       <= '0;
			pos_q       <= '0;
			line_q      <= COUNT_WIDTH'(1);
		end else if (step) begin
			mode_q      <= mode_d;
			ident_cnt_q <= ident_cnt_d;
			pend_q      <= pend_d;
			tsr_q       <= tsr_d;
			pos_q       <= pos_d;
			line_q      <= line_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && pre_we) begin
			prefix_q[pre_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[tail_q] <= r0;
		end
		if (push_n == 2'd2) begin
			fifo_q[tail_q + sclex_pkg::PTR_W'(1)] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			tail_q <= tail_q + sclex_pkg::PTR_W'(push_n);
			if (pop) begin
				head_q <= head_q + sclex_pkg::PTR_W'(1);
			end
			fill_q <= fill_q + sclex_pkg::FILL_W'(push_n) - sclex_pkg::FILL_W'(pop);
		end
	end

	assign token.valid        = (fill_q != '0);
	assign token.token_kind   = fifo_q[head_q].kind;
	assign token.token_start  = fifo_q[head_q].start;
	assign token.token_length = fifo_q[head_q].length;
	assign token.line_number  = fifo_q[head_q].line;
	assign token.unknown_byte = fifo_q[head_q].unknown_byte;
	assign token.run_last     = fifo_q[head_q].run_last;

endmodule

// ----- rtl/core/sclex_checker.sv -----
// sclex_checker: port-level assertions for the source code lexer token channel,
// bound to source_code_lexer_top. Depends on sclex_pkg.

module sclex_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        tok_valid,
	input logic        tok_ready,
	input logic [5:0]  token_kind,
	input logic [15:0] token_length,
	input logic [7:0]  unknown_byte,
	input logic        run_last
);

	// a stalled token holds until its transfer
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(token_kind) &&
		$stable(token_length) && $stable(unknown_byte) && $stable(run_last))
		else $error("token changed while stalled");

	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == sclex_pkg::KIND_EOF |->
		token_length == 16'd0 && unknown_byte == 8'h00 && run_last)
		else $error("end-of-file token malformed");

	a_unknown_only: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind != sclex_pkg::KIND_UNKNOWN |-> unknown_byte == 8'h00)
		else $error("unknown byte set on a known token");

	a_pair_length: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind >= sclex_pkg::KIND_AND_AND &&
		token_kind <= sclex_pkg::KIND_GREATER_EQ |-> token_length == 16'd2)
		else $error("two-byte operator with wrong length");

endmodule

bind source_code_lexer_top sclex_checker u_sclex_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tok_valid    (token.valid),
	.tok_ready    (token.ready),
	.token_kind   (token.token_kind),
	.token_length (token.token_length),
	.unknown_byte (token.unknown_byte),
	.run_last     (token.run_last)
);

// ----- tb/sclex_checker.sv -----
// sclex_scoreboard: watches the text and token channels of the lexer, predicts the tokens
// of every byte transfer and compares them in order. Depends on sclex_pkg and sclex_if.sv.
`timescale 1ns / 100ps

module sclex_scoreboard (
	input  logic  clk,
	input  logic  arst_n,
	sclex_text_if  text,
	sclex_token_if token,
	output int    failures,
	output int    pending
);
	import sclex_pkg::*;

	localparam int COUNT_MAX  = (1 << 16) - 1;
	localparam int WORD_KEEP  = 8;
	localparam int KW_TOTAL   = 9;
	localparam int PRINT_CAP  = 100;

	typedef enum {CC_SPACE, CC_WORD, CC_DIGIT, CC_OPSTART, CC_OTHER} char_class_t;

	// position in this list is the token kind of the keyword
	string kw_words[KW_TOTAL] = '{"function", "if", "else", "while", "return", "int",
		"float", "bool", "string"};

	lex_mode_t   mode;
	logic [7:0]  word_bytes[WORD_KEEP];
	int          word_len;
	logic [7:0]  held_op;
	int          tok_start;
	int          src_pos;
	int          line_no;
	token_t      token_q[$];
	token_t      oldest;
	int          tokens_seen;

	function automatic char_class_t classify(input logic [7:0] c);
		if (c == " " || (c >= 8'd9 && c <= 8'd13)) return CC_SPACE;
		if (c >= "0" && c <= "9") return CC_DIGIT;
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE)
			return CC_WORD;
		case (c)
			"&", "|", "=", "!", "<", ">": return CC_OPSTART;
			default: return CC_OTHER;
		endcase
	endfunction

	function automatic kind_t lone_kind(input logic [7:0] c);
		case (c)
			"=": return KIND_ASSIGN;
			"!": return KIND_NOT;
			"<": return KIND_LESS;
			">": return KIND_GREATER;
			"+": return KIND_PLUS;
			"-": return KIND_MINUS;
			"*": return KIND_STAR;
			"/": return KIND_SLASH;
			"(": return KIND_LPAREN;
			")": return KIND_RPAREN;
			"{": return KIND_LBRACE;
			"}": return KIND_RBRACE;
			",": return KIND_COMMA;
			";": return KIND_SEMI;
			default: return KIND_UNKNOWN;
		endcase
	endfunction

	function automatic kind_t pair_of(input logic [7:0] a, input logic [7:0] b);
		case ({a, b})
			"&&": return KIND_AND_AND;
			"||": return KIND_OR_OR;
			"==": return KIND_EQ_EQ;
			"!=": return KIND_NOT_EQ;
			"<=": return KIND_LESS_EQ;
			">=": return KIND_GREATER_EQ;
			default: return KIND_NONE;
		endcase
	endfunction

	// words longer than the kept prefix never match, their count sits past every keyword
	function automatic kind_t word_kind();
		kind_t k;
		bit    hit;
		k = KIND_IDENT;
		for (int i = 0; i < KW_TOTAL; i++) begin
			hit = (kw_words[i].len() == word_len);
			if (hit) begin
				for (int j = 0; j < word_len; j++)
					if (word_bytes[j] != kw_words[i][j]) hit = 1'b0;
			end
			if (hit && k == KIND_IDENT) k = kind_t'(i);
		end
		return k;
	endfunction

	function automatic void add_token(input kind_t k, input int start, input int len,
		input logic [7:0] unk);
		token_t t;
		t.kind         = k;
		t.start        = start[15:0];
		t.length       = len[15:0];
		t.line         = line_no[15:0];
		t.unknown_byte = unk;
		t.run_last     = 1'b0;
		token_q = {token_q, t};
	endfunction

	function automatic void add_lone(input logic [7:0] c, input int start);
		kind_t k;
		k = lone_kind(c);
		add_token(k, start, 1, (k == KIND_UNKNOWN) ? c : 8'h00);
	endfunction

	function automatic void close_pending();
		case (mode)
			MODE_IDENT: add_token(word_kind(), tok_start, src_pos - tok_start, 8'h00);
			MODE_INT, MODE_FRAC: add_token(KIND_NUMBER, tok_start, src_pos - tok_start, 8'h00);
			MODE_OP: add_lone(held_op, tok_start);
			default: ;
		endcase
		mode = MODE_IDLE;
	endfunction

	function automatic void take_word_byte(input logic [7:0] c);
		if (word_len < WORD_KEEP) word_bytes[word_len] = c;
		if (word_len <= WORD_KEEP) word_len++;
	endfunction

	function automatic void open_token(input logic [7:0] c);
		case (classify(c))
			CC_SPACE: if (c == CH_NEWLINE && line_no < COUNT_MAX) line_no++;
			CC_WORD: begin
				mode = MODE_IDENT;
				tok_start = src_pos;
				word_len = 0;
				take_word_byte(c);
			end
			CC_DIGIT: begin
				mode = MODE_INT;
				tok_start = src_pos;
			end
			CC_OPSTART: begin
				mode = MODE_OP;
				held_op = c;
				tok_start = src_pos;
			end
			default: add_lone(c, src_pos);
		endcase
	endfunction

	function automatic void predict(input logic [7:0] c, input logic eoi);
		int          prior_count;
		char_class_t cls;
		kind_t       pk;
		prior_count = token_q.size();
		cls = classify(c);
		if (eoi) begin
			close_pending();
			add_token(KIND_EOF, src_pos, 0, 8'h00);
		end else begin
			case (mode)
				MODE_IDENT: begin
					if (cls == CC_WORD || cls == CC_DIGIT) take_word_byte(c);
					else begin
						close_pending();
						open_token(c);
					end
				end
				MODE_INT: begin
					if (c == CH_DOT) mode = MODE_FRAC;
					else if (cls != CC_DIGIT) begin
						close_pending();
						open_token(c);
					end
				end
				MODE_FRAC: begin
					if (cls != CC_DIGIT) begin
						close_pending();
						open_token(c);
					end
				end
				MODE_OP: begin
					pk = pair_of(held_op, c);
					if (pk != KIND_NONE) begin
						add_token(pk, tok_start, 2, 8'h00);
						mode = MODE_IDLE;
					end else begin
						close_pending();
						open_token(c);
					end
				end
				default: open_token(c);
			endcase
			if (src_pos < COUNT_MAX) src_pos++;
		end
		if (token_q.size() > prior_count) token_q[token_q.size() - 1].run_last = 1'b1;
	endfunction

	task automatic report(input string msg);
		if (failures < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
		failures++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report($sformatf("token %0d %s got %0h expected %0h", tokens_seen, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_IDLE;
			foreach (word_bytes[i]) word_bytes[i] = 8'h00;
			word_len = 0;
			held_op = 8'h00;
			tok_start = 0;
			src_pos = 0;
			line_no = 1;
			token_q.delete();
			tokens_seen = 0;
			failures = 0;
		end else begin
			// results leave only after their byte has been registered and lexed, so check before predicting
			if (token.valid && token.ready) begin
				if (token_q.size() == 0) begin
					report($sformatf("token %0d kind %0d arrived with nothing expected",
						tokens_seen, token.token_kind));
				end else begin
					oldest = token_q.pop_front();
					check_field("kind", 16'(token.token_kind), 16'(oldest.kind));
					check_field("start", token.token_start, oldest.start);
					check_field("length", token.token_length, oldest.length);
					check_field("line", token.line_number, oldest.line);
					check_field("unknown byte", 16'(token.unknown_byte), 16'(oldest.unknown_byte));
					check_field("run last", 16'(token.run_last), 16'(oldest.run_last));
				end
				tokens_seen++;
			end
			if (text.valid && text.ready) predict(text.ch_byte, text.end_of_input);
		end
		pending = token_q.size();
	end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: drives source text into source_code_lexer_top with bursty input and a stalling
// token receiver; sclex_scoreboard predicts and compares. Depends on sclex_pkg and sclex_if.sv.
`timescale 1ns / 100ps

module tb_top;
	import sclex_pkg::*;

	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int KW_TOTAL     = 9;
	localparam int OP_TOTAL     = 22;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   items_sent;
	int   burst_left;
	int   idle_cycles;
	bit   steady;
	bit   hold_req;
	bit   hold_done;

	string kw_words[KW_TOTAL] = '{"function", "if", "else", "while", "return", "int",
		"float", "bool", "string"};
	string op_words[OP_TOTAL] = '{"&&", "||", "==", "!=", "<=", ">=", "=", "!", "<", ">",
		"+", "-", "*", "/", "(", ")", "{", "}", ",", ";", "&", "|"};
	string odd_chars = "#$%@^~?:[]\\\"'.";
	logic [7:0] lexeme_q[$];

	sclex_text_if  text_ch();
	sclex_token_if token_ch();

	source_code_lexer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.token  (token_ch)
	);

	sclex_scoreboard chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text_ch),
		.token    (token_ch),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one transfer on the text channel, with a random gap at the start of each burst
	task automatic send_item(input logic [7:0] b, input logic eoi);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0 || steady) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_ch.valid <= 1'b1;
		text_ch.ch_byte <= b;
		text_ch.end_of_input <= eoi;
		do @(posedge clk); while (!text_ch.ready);
		items_sent++;
	endtask

	task automatic send_end();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_lexeme();
		while (lexeme_q.size() > 0) send_item(lexeme_q.pop_front(), 1'b0);
	endtask

	function automatic void append_byte(input logic [7:0] c);
		lexeme_q = {lexeme_q, c};
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) append_byte(s[i]);
	endfunction

	function automatic logic [7:0] word_char(input bit lead);
		int r;
		r = $urandom_range(0, lead ? 52 : 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return CH_UNDERSCORE;
		return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] digit_char();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	// mostly well-formed lexemes, some run together, plus stray and high bytes
	function automatic void build_lexeme();
		int         pick;
		int         n;
		string      w;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			w = kw_words[$urandom_range(0, KW_TOTAL - 1)];
			case ($urandom_range(0, 6))
				0: w = {w, "s"};
				1: w = w.substr(0, w.len() - 2);
				2: w = {w, "_long"};
				3: w[0] = w[0] - 8'd32;
				default: ;
			endcase
			push_text(w);
		end else if (pick < 35) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			append_byte(word_char(1'b1));
			repeat (n - 1) append_byte(word_char(1'b0));
		end else if (pick < 50) begin
			repeat ($urandom_range(1, 5)) append_byte(digit_char());
			if ($urandom_range(0, 1) == 1) begin
				append_byte(CH_DOT);
				repeat ($urandom_range(0, 4)) append_byte(digit_char());
				if ($urandom_range(0, 5) == 0) append_byte(CH_DOT);
			end
		end else if (pick < 70) begin
			push_text(op_words[$urandom_range(0, OP_TOTAL - 1)]);
		end else if (pick < 80) begin
			case ($urandom_range(0, 2))
				0: c = 8'($urandom_range(128, 255));
				1: c = odd_chars[$urandom_range(0, odd_chars.len() - 1)];
				default: begin
					n = $urandom_range(0, 27);
					c = (n < 9) ? 8'(n) : (n < 27) ? 8'(n + 5) : 8'd127;
				end
			endcase
			append_byte(c);
		end else if (pick < 92) begin
			append_byte(($urandom_range(0, 5) == 0) ? 8'(" ") : 8'($urandom_range(9, 13)));
		end else begin
			append_byte(8'($urandom_range(0, 255)));
		end
		case ($urandom_range(0, 5))
			0, 1: append_byte(8'(" "));
			2: append_byte(CH_NEWLINE);
			default: ;
		endcase
	endfunction

	task automatic random_stream(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if (items_sent > stop_at - count / 2) hold_req = 1'b1;
			build_lexeme();
			send_lexeme();
			if ($urandom_range(0, 59) == 0) repeat ($urandom_range(1, 2)) send_end();
		end
	endtask

	// token receiver: stall styles in spans, and one long hold-off
	initial begin
		int style;
		int span;
		int k;
		token_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				token_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			style = $urandom_range(0, 3);
			span = $urandom_range(8, 80);
			for (k = 0; k < span; k++) begin
				case (style)
					0: token_ch.ready <= 1'b1;
					1: token_ch.ready <= ($urandom_range(0, 1) == 1);
					2: token_ch.ready <= (k % 4 != 3);
					default: token_ch.ready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		items_sent = 0;
		burst_left = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.ch_byte <= 8'h00;
		text_ch.end_of_input <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pair and lone operators, a number closed by a second dot, null and high bytes,
		// then an end transfer that flushes a pending operator
		push_text("if x>=2.5.;a&&b|c!=\n");
		append_byte(8'h00);
		append_byte(8'hff);
		push_text("_9<");
		send_lexeme();
		send_end();

		random_stream(RANDOM_ITEMS);

		push_text("while 12.5 ");
		send_lexeme();
		random_stream(80);
		send_end();

		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
